/* sv/ptt_pkg.sv */
`default_nettype none

package ptt_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int REQ_W          = 3;
    localparam int ID_W           = 8;
    localparam int PERIOD_W       = 15;
    localparam int KIND_W         = 3;
    localparam int SLOT_W         = 3;
    localparam int FCNT_W         = $clog2(MAX_RESULTS + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_SET     = 3'd1,
        REQ_KILL    = 3'd2,
        REQ_TIMEOUT = 3'd3,
        REQ_QUERY   = 3'd4
    } t_req;

    // Result kinds share their codes with the request that causes them.
    localparam logic [KIND_W-1:0] KIND_FIRE = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ANSWER,
        EMIT_MISS,
        EMIT_FIRE,
        EMIT_FLUSH
    } t_emit;

    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
        logic                notify;
    } t_entry;

    typedef struct packed {
        logic  load;
        logic  step;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic in_known;
        logic is_tick;
        logic hit;
        logic fire_new;
        logic held_valid;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* sv/ptt_ctrl.sv */
`default_nettype none

module ptt_ctrl #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
    parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  ptt_pkg::t_status     i_status,
    output ptt_pkg::t_cmd        o_cmd,
    output logic [IDX_W-1:0]     o_idx,
    output logic [IDX_W-1:0]     o_rd_addr
);
    import ptt_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.emit = EMIT_NONE;
        o_in_stall = 1'b1;
        last_idx   = (r_idx == IDX_W'(NUM_TIMERS - 1));
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    if (i_status.in_known) begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.is_tick) begin
                        if (i_status.fire_new && i_status.held_valid) begin
                            o_cmd.emit = EMIT_FIRE;
                        end
                        if (last_idx) begin
                            n_idx   = '0;
                            n_state = (i_status.held_valid || i_status.fire_new) ?
                                      ST_FLUSH : ST_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else if (i_status.hit) begin
                        o_cmd.emit = EMIT_ANSWER;
                        n_idx      = '0;
                        n_state    = ST_IDLE;
                    end else if (last_idx) begin
                        o_cmd.emit = EMIT_MISS;
                        n_idx      = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_FLUSH;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idx     = r_idx;
    assign o_rd_addr = n_idx;

    // The closing fire event is only ever sent from a held one.
    a_flush_has_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> i_status.held_valid)
        else $error("flush state without a held fire event");

endmodule

`default_nettype wire

/* sv/ptt_datapath.sv */
`default_nettype none

module ptt_datapath #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
    parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [ptt_pkg::REQ_W-1:0]        i_req_type,
    input  wire  [ptt_pkg::ID_W-1:0]         i_entry_id,
    input  wire  [ptt_pkg::PERIOD_W-1:0]     i_period,
    input  wire                              i_restart_only,
    input  wire                              i_notify_enable,
    input  wire                              i_out_stall,
    input  ptt_pkg::t_cmd                    i_cmd,
    input  wire  [IDX_W-1:0]                 i_idx,
    input  wire  [IDX_W-1:0]                 i_rd_addr,
    output ptt_pkg::t_status                 o_status,
    output logic                             o_out_valid,
    output logic [ptt_pkg::KIND_W-1:0]       o_resp_kind,
    output logic [ptt_pkg::SLOT_W-1:0]       o_slot,
    output logic [ptt_pkg::ID_W-1:0]         o_fired_id,
    output logic                             o_ok,
    output logic                             o_count_nonzero,
    output logic                             o_last
);
    import ptt_pkg::*;

    // Request held for the length of the walk.
    t_req                r_req;
    logic [ID_W-1:0]     r_id;
    logic [PERIOD_W-1:0] r_period;
    logic                r_restart;
    logic                r_notify;

    // Table: valid bits in flops, entry contents in a memory.
    logic [NUM_TIMERS-1:0] r_valid;
    t_entry                r_mem [NUM_TIMERS];
    t_entry                r_rd;

    // Fire event held back until it is known whether it is the last one.
    logic              r_held_valid;
    logic [SLOT_W-1:0] r_held_slot;
    logic [ID_W-1:0]   r_held_id;
    logic [FCNT_W-1:0] r_fire_cnt;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [SLOT_W-1:0] r_slot;
    logic [ID_W-1:0]   r_out_id;
    logic              r_ok;
    logic              r_nz;
    logic              r_last;
    logic [KIND_W-1:0] n_kind;
    logic [SLOT_W-1:0] n_slot;
    logic [ID_W-1:0]   n_out_id;
    logic              n_ok;
    logic              n_nz;
    logic              n_last;

    logic                    cur_valid;
    logic                    cnt_nz;
    logic                    is_tick;
    logic                    hit;
    logic                    fire_new;
    logic                    in_known;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [SLOT_W-1:0]       cur_slot;
    logic                    wr_en;
    t_entry                  wr_data;

    always_comb begin
        cur_valid = r_valid[i_idx];
        cnt_nz    = (r_rd.count != '0);
        is_tick   = (r_req == REQ_TICK);
        slot_ext  = {{SLOT_W{1'b0}}, i_idx};
        cur_slot  = slot_ext[SLOT_W-1:0];
        case (r_req)
            REQ_SET:                         hit = !cur_valid && (r_id != '0);
            REQ_KILL, REQ_TIMEOUT, REQ_QUERY: hit = cur_valid && (r_rd.ident == r_id);
            default:                         hit = 1'b0;
        endcase
        fire_new = is_tick && cur_valid && !cnt_nz && r_rd.notify &&
                   (r_fire_cnt < FCNT_W'(MAX_RESULTS));
        case (t_req'(i_req_type))
            REQ_TICK, REQ_SET, REQ_KILL, REQ_TIMEOUT, REQ_QUERY: in_known = 1'b1;
            default:                                             in_known = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_rd;
        if (i_cmd.step) begin
            case (r_req)
                REQ_TICK: begin
                    if (cur_valid && cnt_nz) begin
                        wr_data.count = r_rd.count - 1'b1;
                        wr_en         = 1'b1;
                    end else if (cur_valid && r_rd.notify) begin
                        wr_data.count = r_rd.period;
                        wr_en         = 1'b1;
                    end
                end
                REQ_SET: begin
                    if (hit) begin
                        wr_data.ident  = r_id;
                        wr_data.period = r_period;
                        wr_data.count  = r_period;
                        wr_data.notify = r_notify;
                        wr_en          = 1'b1;
                    end
                end
                REQ_TIMEOUT: begin
                    if (hit) begin
                        if (r_restart) begin
                            wr_data.count = r_rd.period;
                        end else begin
                            wr_data.count  = r_period;
                            wr_data.period = r_period;
                        end
                        wr_en = 1'b1;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_kind   = r_kind;
        n_slot   = r_slot;
        n_out_id = r_out_id;
        n_ok     = r_ok;
        n_nz     = r_nz;
        n_last   = r_last;
        case (i_cmd.emit)
            EMIT_ANSWER: begin
                n_kind   = KIND_W'(r_req);
                n_slot   = cur_slot;
                n_out_id = r_id;
                n_ok     = 1'b1;
                n_nz     = (r_req == REQ_QUERY) && cnt_nz;
                n_last   = 1'b1;
            end
            EMIT_MISS: begin
                n_kind   = KIND_W'(r_req);
                n_slot   = '0;
                n_out_id = r_id;
                n_ok     = 1'b0;
                n_nz     = 1'b0;
                n_last   = 1'b1;
            end
            EMIT_FIRE, EMIT_FLUSH: begin
                n_kind   = KIND_FIRE;
                n_slot   = r_held_slot;
                n_out_id = r_held_id;
                n_ok     = 1'b1;
                n_nz     = 1'b0;
                n_last   = (i_cmd.emit == EMIT_FLUSH);
            end
            default: begin
                n_last = r_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_idx] <= wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= t_req'(i_req_type);
            r_id      <= i_entry_id;
            r_period  <= i_period;
            r_restart <= i_restart_only;
            r_notify  <= i_notify_enable;
        end
        if (i_cmd.emit != EMIT_NONE) begin
            r_kind   <= n_kind;
            r_slot   <= n_slot;
            r_out_id <= n_out_id;
            r_ok     <= n_ok;
            r_nz     <= n_nz;
            r_last   <= n_last;
        end
        if (i_cmd.step && fire_new) begin
            r_held_slot <= cur_slot;
            r_held_id   <= r_rd.ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_held_valid <= 1'b0;
            r_fire_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.step && hit && (r_req == REQ_SET)) begin
                r_valid[i_idx] <= 1'b1;
            end else if (i_cmd.step && hit && (r_req == REQ_KILL)) begin
                r_valid[i_idx] <= 1'b0;
            end
            if (i_cmd.load) begin
                r_held_valid <= 1'b0;
                r_fire_cnt   <= '0;
            end else if (i_cmd.step && fire_new) begin
                r_held_valid <= 1'b1;
                r_fire_cnt   <= r_fire_cnt + 1'b1;
            end else if (i_cmd.emit == EMIT_FLUSH) begin
                r_held_valid <= 1'b0;
            end
            if (i_cmd.emit != EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.in_known   = in_known;
        o_status.is_tick    = is_tick;
        o_status.hit        = hit;
        o_status.fire_new   = fire_new;
        o_status.held_valid = r_held_valid;
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_resp_kind     = r_kind;
    assign o_slot          = r_slot;
    assign o_fired_id      = r_out_id;
    assign o_ok            = r_ok;
    assign o_count_nonzero = r_nz;
    assign o_last          = r_last;

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fire_cnt <= FCNT_W'(MAX_RESULTS))
        else $error("fire event count above the result limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> (i_cmd.emit == EMIT_NONE))
        else $error("stalled result overwritten");

    a_held_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_fire_cnt != '0))
        else $error("held fire event not counted");

endmodule

`default_nettype wire

/* sv/periodic_timer_table.sv */
// Periodic timer table with NUM_TIMERS slots.
// Input channel: i_in_valid / o_in_stall carry one request beat (tick, set,
// kill, timeout or query). A beat is taken when i_in_valid is high and
// o_in_stall is low; the block takes one request at a time.
// Output channel: o_out_valid / i_out_stall carry result beats from an output
// register. Set, kill, timeout and query give exactly one beat each; a tick
// gives one beat per firing entry (at most eight), and o_last marks the final
// beat of a request. Unknown request codes are taken and give no beat.
// Sequencing: the request is taken, then a sequencer walks the table one slot
// per cycle while the output is free, since the entries sit in a memory with
// a registered read port. A lookup ends at the matching slot; a tick always
// walks all slots and sends its final fire event from a flush state after
// the walk when any entry fires.
// Reset (synchronous, active low) clears the valid bits, so the table starts
// empty, and it empties the output register; entry contents need no clearing.
// When the receiver stalls, the waiting beat holds and the walk pauses at the
// current slot until that beat is taken.
`default_nettype none

module periodic_timer_table #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
    parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [ptt_pkg::REQ_W-1:0]    i_req_type,
    input  wire  [ptt_pkg::ID_W-1:0]     i_entry_id,
    input  wire  [ptt_pkg::PERIOD_W-1:0] i_period,
    input  wire                          i_restart_only,
    input  wire                          i_notify_enable,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [ptt_pkg::KIND_W-1:0]   o_resp_kind,
    output logic [ptt_pkg::SLOT_W-1:0]   o_slot,
    output logic [ptt_pkg::ID_W-1:0]     o_fired_id,
    output logic                         o_ok,
    output logic                         o_count_nonzero,
    output logic                         o_last
);
    import ptt_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_addr;

    // The controller sequences the walk over the slots; the datapath holds
    // the table, evaluates the current slot and owns the output register.
    ptt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_rd_addr  (rd_addr)
    );

    ptt_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_entry_id      (i_entry_id),
        .i_period        (i_period),
        .i_restart_only  (i_restart_only),
        .i_notify_enable (i_notify_enable),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .i_rd_addr       (rd_addr),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_resp_kind     (o_resp_kind),
        .o_slot          (o_slot),
        .o_fired_id      (o_fired_id),
        .o_ok            (o_ok),
        .o_count_nonzero (o_count_nonzero),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

/* tb/periodic_timer_table_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the periodic timer table. Requests go in as beats on
// the input channel. A behavioral copy of the table, kept here in plain
// arrays, works out the response beats that every accepted request must
// produce. Those beats wait in a queue until the output channel delivers
// them, and each delivered beat is compared field by field with the oldest
// one waiting.
module periodic_timer_table_tb;

    import ptt_pkg::*;

    localparam int TABLE_DEPTH      = NUM_TIMERS_DEF;
    localparam int LONG_HOLD_CYCLES = 160;
    // Codes 5 to 7 are not requests. The block takes them and stays silent.
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   ident;
        logic              ok;
        logic              count_nz;
        logic              last;
    } t_timer_response;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [REQ_W-1:0]    i_req_type;
    logic [ID_W-1:0]     i_entry_id;
    logic [PERIOD_W-1:0] i_period;
    logic                i_restart_only;
    logic                i_notify_enable;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [KIND_W-1:0]   o_resp_kind;
    logic [SLOT_W-1:0]   o_slot;
    logic [ID_W-1:0]     o_fired_id;
    logic                o_ok;
    logic                o_count_nonzero;
    logic                o_last;

    // Our own copy of the timer table. Slots that are not live are never read.
    bit                  slot_live   [TABLE_DEPTH];
    logic [ID_W-1:0]     slot_ident  [TABLE_DEPTH];
    logic [PERIOD_W-1:0] slot_period [TABLE_DEPTH];
    logic [PERIOD_W-1:0] slot_count  [TABLE_DEPTH];
    bit                  slot_notify [TABLE_DEPTH];

    // Response beats that accepted requests still owe, oldest first.
    t_timer_response timer_responses_due[$];

    int mismatch_count = 0;
    // Percentages for random idling on each side. A long output hold is
    // requested through long_hold_req.
    int tx_gap_pct     = 30;
    int rx_stall_pct   = 30;
    bit long_hold_req  = 1'b0;

    periodic_timer_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_entry_id      (i_entry_id),
        .i_period        (i_period),
        .i_restart_only  (i_restart_only),
        .i_notify_enable (i_notify_enable),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_resp_kind     (o_resp_kind),
        .o_slot          (o_slot),
        .o_fired_id      (o_fired_id),
        .o_ok            (o_ok),
        .o_count_nonzero (o_count_nonzero),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Lowest live slot that holds the identifier, or -1. Identifier zero never
    // matches, because a set with identifier zero is always refused.
    function automatic int find_live_entry(logic [ID_W-1:0] id);
        int k;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            if (slot_live[k] && slot_ident[k] == id) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Applies one accepted request to the table copy and queues the beats it
    // must produce.
    function automatic void apply_timer_request(logic [REQ_W-1:0] req,
                                                logic [ID_W-1:0] id,
                                                logic [PERIOD_W-1:0] per,
                                                logic restart, logic notify);
        t_timer_response   rsp;
        logic [SLOT_W-1:0] fire_slot  [MAX_RESULTS];
        logic [ID_W-1:0]   fire_ident [MAX_RESULTS];
        int                nfire;
        int                hit;
        int                k;
        nfire = 0;
        hit = -1;
        rsp = '0;
        rsp.kind = KIND_W'(req);
        rsp.ident = id;
        rsp.last = 1'b1;
        case (req)
            REQ_TICK: begin
                // Walk the live slots in order. A running countdown steps
                // down; an expired one with notify set reloads and fires.
                for (k = 0; k < TABLE_DEPTH; k++) begin
                    if (slot_live[k]) begin
                        if (slot_count[k] != '0) begin
                            slot_count[k] = slot_count[k] - 1'b1;
                        end else if (slot_notify[k]) begin
                            slot_count[k] = slot_period[k];
                            if (nfire < MAX_RESULTS) begin
                                fire_slot[nfire] = SLOT_W'(k);
                                fire_ident[nfire] = slot_ident[k];
                                nfire++;
                            end
                        end
                    end
                end
                for (k = 0; k < nfire; k++) begin
                    rsp.kind = KIND_FIRE;
                    rsp.slot = fire_slot[k];
                    rsp.ident = fire_ident[k];
                    rsp.ok = 1'b1;
                    rsp.last = (k == nfire - 1);
                    timer_responses_due.push_back(rsp);
                end
            end
            REQ_SET: begin
                if (id != '0) begin
                    for (k = TABLE_DEPTH - 1; k >= 0; k--) begin
                        if (!slot_live[k]) begin
                            hit = k;
                        end
                    end
                end
                if (hit >= 0) begin
                    slot_live[hit] = 1'b1;
                    slot_ident[hit] = id;
                    slot_period[hit] = per;
                    slot_count[hit] = per;
                    slot_notify[hit] = notify;
                    rsp.slot = SLOT_W'(hit);
                    rsp.ok = 1'b1;
                end
                timer_responses_due.push_back(rsp);
            end
            REQ_KILL, REQ_TIMEOUT, REQ_QUERY: begin
                hit = find_live_entry(id);
                if (hit >= 0) begin
                    rsp.slot = SLOT_W'(hit);
                    rsp.ok = 1'b1;
                    if (req == REQ_KILL) begin
                        slot_live[hit] = 1'b0;
                    end else if (req == REQ_TIMEOUT) begin
                        if (restart) begin
                            slot_count[hit] = slot_period[hit];
                        end else begin
                            slot_count[hit] = per;
                            slot_period[hit] = per;
                        end
                    end else begin
                        rsp.count_nz = (slot_count[hit] != '0);
                    end
                end
                timer_responses_due.push_back(rsp);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void compare_field(string name, int expected, int actual);
        if (expected != actual) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
            mismatch_count++;
        end
    endfunction

    // One process watches both channels at every rising edge. The output beat
    // is checked before the input beat is predicted, since a request accepted
    // at this edge cannot have produced a beat yet.
    always @(posedge i_clk) begin
        t_timer_response due;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (timer_responses_due.size() == 0) begin
                    $display("%0t ns: response beat with none expected, kind %0d slot %0d id %0d",
                             $time, o_resp_kind, o_slot, o_fired_id);
                    mismatch_count++;
                end else begin
                    due = timer_responses_due.pop_front();
                    compare_field("resp_kind", due.kind, o_resp_kind);
                    compare_field("slot", due.slot, o_slot);
                    compare_field("fired_id", due.ident, o_fired_id);
                    compare_field("ok", due.ok, o_ok);
                    compare_field("count_nonzero", due.count_nz, o_count_nonzero);
                    compare_field("last", due.last, o_last);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                apply_timer_request(i_req_type, i_entry_id, i_period,
                                    i_restart_only, i_notify_enable);
            end
        end
    end

    // Idle stretches are mostly short and now and then long.
    function automatic int idle_length();
        if ($urandom_range(99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // The receiving side. It stalls at random, holds off for a long stretch
    // when asked, and otherwise never stalls while rx_stall_pct is zero.
    initial begin : response_sink
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
                i_out_stall <= 1'b1;
                repeat (idle_length()) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Presents one request beat and returns at the edge that accepts it. Valid
    // stays high, so the next beat can follow without a gap.
    task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                logic [PERIOD_W-1:0] per, logic restart,
                                logic notify);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_entry_id <= id;
        i_period <= per;
        i_restart_only <= restart;
        i_notify_enable <= notify;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic sender_pause();
        if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat (idle_length()) @(posedge i_clk);
        end
    endtask

    task automatic send_and_pause(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                  logic [PERIOD_W-1:0] per, logic restart,
                                  logic notify);
        send_request(req, id, per, restart, notify);
        sender_pause();
    endtask

    // Mostly an identifier that is live in the table, so that lookups hit.
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] live_ids [TABLE_DEPTH];
        int              nlive;
        int              k;
        nlive = 0;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            if (slot_live[k]) begin
                live_ids[nlive] = slot_ident[k];
                nlive++;
            end
        end
        if (nlive > 0 && $urandom_range(9) < 7) begin
            return live_ids[$urandom_range(nlive - 1)];
        end
        return ID_W'($urandom_range(255));
    endfunction

    // Short periods keep the timers firing. Now and then the full range is
    // used so that every period bit is exercised.
    function automatic logic [PERIOD_W-1:0] pick_period();
        if ($urandom_range(5) == 0) begin
            return PERIOD_W'($urandom_range(32767));
        end
        return PERIOD_W'($urandom_range(5));
    endfunction

    // Lookups on an empty table, a refused set, a silent tick and an unused
    // request code.
    task automatic test_empty_table();
        send_and_pause(REQ_TICK, 8'd0, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_KILL, 8'd17, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_TIMEOUT, 8'd0, 15'h7fff, 1'b1, 1'b1);
        send_and_pause(REQ_QUERY, 8'hff, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_SET, 8'd0, 15'd3, 1'b0, 1'b1);
        send_and_pause(REQ_LAST_UNUSED, 8'hff, 15'h7fff, 1'b1, 1'b1);
    endtask

    // Fills every slot, including a duplicate identifier, a zero period with
    // and without notify and the largest period, then overfills.
    task automatic test_fill_table();
        send_and_pause(REQ_SET, 8'hff, 15'h7fff, 1'b0, 1'b1);
        send_and_pause(REQ_SET, 8'd1, 15'd0, 1'b0, 1'b1);
        send_and_pause(REQ_SET, 8'd2, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_SET, 8'd3, 15'd1, 1'b0, 1'b1);
        send_and_pause(REQ_SET, 8'd1, 15'd2, 1'b0, 1'b1);
        send_and_pause(REQ_SET, 8'd5, 15'd1, 1'b1, 1'b1);
        send_and_pause(REQ_SET, 8'd6, 15'd0, 1'b0, 1'b1);
        send_and_pause(REQ_SET, 8'd7, 15'd1, 1'b0, 1'b0);
        send_and_pause(REQ_SET, 8'd9, 15'd4, 1'b0, 1'b1);
    endtask

    // Ticks with several fire events, queries on zero and running counts, both
    // timeout forms, a kill that exposes the duplicate behind it and a kill that misses.
    task automatic test_lookups_and_ticks();
        send_and_pause(REQ_TICK, 8'd0, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_TICK, 8'd0, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_QUERY, 8'd2, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_QUERY, 8'hff, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_TIMEOUT, 8'hff, 15'd0, 1'b1, 1'b0);
        send_and_pause(REQ_TIMEOUT, 8'd3, 15'h7fff, 1'b0, 1'b0);
        send_and_pause(REQ_KILL, 8'd1, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_QUERY, 8'd1, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_KILL, 8'd99, 15'd0, 1'b0, 1'b0);
        send_and_pause(REQ_TICK, 8'd0, 15'd0, 1'b0, 1'b0);
    endtask

    // Random traffic. Unused request codes are sent as noise and do not count.
    task automatic random_requests(int count);
        int                  done;
        int                  r;
        logic [REQ_W-1:0]    req;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] per;
        logic                restart;
        logic                notify;
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            id = pick_id();
            per = pick_period();
            restart = $urandom_range(1);
            notify = ($urandom_range(3) != 0);
            if (r < 35) begin
                req = REQ_TICK;
            end else if (r < 55) begin
                req = REQ_SET;
                if ($urandom_range(19) == 0) begin
                    id = '0;
                end else if ($urandom_range(4) != 0) begin
                    id = ID_W'($urandom_range(1, 255));
                end
            end else if (r < 67) begin
                req = REQ_KILL;
            end else if (r < 81) begin
                req = REQ_TIMEOUT;
            end else if (r < 96) begin
                req = REQ_QUERY;
            end else begin
                req = REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
            end
            send_request(req, id, per, restart, notify);
            if (req <= REQ_QUERY) begin
                done++;
            end
            sender_pause();
        end
    endtask

    task automatic test_random_traffic();
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        random_requests(125);
    endtask

    // Beats back to back on both sides, with no idling at all.
    task automatic test_streaming();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        random_requests(40);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats, so the block fills up and stalls its input.
    task automatic test_output_hold();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        long_hold_req = 1'b1;
        random_requests(40);
    endtask

    initial begin
        int k;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            slot_live[k] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_TICK;
        i_entry_id = '0;
        i_period = '0;
        i_restart_only = 1'b0;
        i_notify_enable = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_table();
        test_lookups_and_ticks();
        test_random_traffic();
        test_streaming();
        test_output_hold();

        // Drain, then allow a full tick walk and a receiver stall for any
        // stray beat to show up.
        i_in_valid <= 1'b0;
        rx_stall_pct = 0;
        while (timer_responses_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("%0t ns: timeout, %0d response beats still due",
                 $time, timer_responses_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
sv/ptt_pkg.sv
sv/ptt_ctrl.sv
sv/ptt_datapath.sv
sv/periodic_timer_table.sv
tb/periodic_timer_table_tb.sv
